[hdl/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants and types for the bitmap frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    localparam int WORD_BITS      = 32;
    localparam int WORD_LOG2      = 5;
    localparam int MAX_BLOCKS_DEF = 32768;
    localparam int BLOCK_SIZE_DEF = 4096;

    typedef enum logic [2:0] {
        OP_INIT        = 3'd0,
        OP_REGION_FREE = 3'd1,
        OP_REGION_USED = 3'd2,
        OP_ALLOC       = 3'd3,
        OP_FREE_RUN    = 3'd4
    } op_t;

    // Outcome of scanning one bitmap word for a free run.
    typedef struct packed {
        logic                 found;
        logic [WORD_LOG2-1:0] pos;
    } scan_hit_t;

endpackage

`default_nettype wire

[hdl/bfa_bitmap_ram.sv]
// ----------------------------------------------------------------------------
// bfa_bitmap_ram
// Bitmap store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_bitmap_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic [bfa_pkg::WORD_BITS-1:0] wdata,
    input  wire logic [AW-1:0]                 raddr,
    output logic      [bfa_pkg::WORD_BITS-1:0] rdata
);

    logic [bfa_pkg::WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/bfa_word_scan.sv]
// ----------------------------------------------------------------------------
// bfa_word_scan
// Finds where a free run reaches the requested length inside one word.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_word_scan #(
    parameter int RW = 17
) (
    input  wire logic [bfa_pkg::WORD_BITS-1:0] word,
    input  wire logic [RW-1:0]                 run_in,
    input  wire logic [RW-1:0]                 len,
    output bfa_pkg::scan_hit_t                 hit,
    output logic      [RW-1:0]                 run_out
);

    logic [RW-1:0] runlen [bfa_pkg::WORD_BITS];

    // Free run ending at each bit: distance to the last used bit at or below
    // it, or the carried run plus the bit offset when the low part is free.
    always_comb begin
        logic                         any_used;
        logic [bfa_pkg::WORD_LOG2-1:0] last_used;
        for (int b = 0; b < bfa_pkg::WORD_BITS; b++) begin
            any_used  = 1'b0;
            last_used = '0;
            for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
                if (i <= b && word[i]) begin
                    any_used  = 1'b1;
                    last_used = bfa_pkg::WORD_LOG2'(i);
                end
            end
            if (any_used) begin
                runlen[b] = RW'(bfa_pkg::WORD_LOG2'(b) - last_used);
            end else begin
                runlen[b] = run_in + RW'(b + 1);
            end
        end
    end

    always_comb begin
        hit.found = 1'b0;
        hit.pos   = '0;
        for (int b = bfa_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (runlen[b] >= len) begin
                hit.found = 1'b1;
                hit.pos   = bfa_pkg::WORD_LOG2'(b);
            end
        end
    end

    assign run_out = runlen[bfa_pkg::WORD_BITS-1];

endmodule

`default_nettype wire

[hdl/bitmap_frame_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Bitmap page frame allocator with a used-block count, one result per beat.
// ----------------------------------------------------------------------------
// Operation: init performs a full bitmap fill. Region and run opcodes walk
//   each bitmap word touched (region free then re-marks block 0 as used).
//   Allocate scans words (up to total/32) and then marks the words of the run.
// Throughput: one item at a time; the single bitmap memory port sets the rate.
// Reset: control state clears and a fill sweep sets every bitmap
//   word to all ones; no input beat is taken until the fill is done.
`default_nettype none

module bitmap_frame_allocator #(
    parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
    parameter int BLOCK_SIZE = bfa_pkg::BLOCK_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [17:0] cfg_memory_size_kib,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [31:0] s_request_address,
    input  wire logic [31:0] s_run_length,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_result_address,
    output logic             m_success,
    output logic [15:0]      m_used_count,
    output logic [15:0]      m_free_count
);

    localparam int MAP_WORDS = MAX_BLOCKS / bfa_pkg::WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = AW + bfa_pkg::WORD_LOG2;   // block index
    localparam int CW        = $clog2(MAX_BLOCKS + 1);    // block count
    localparam int RW        = CW + 1;                    // run length
    localparam int BS_LOG2   = $clog2(BLOCK_SIZE);
    localparam int TW        = 28;                        // KiB * 1024

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SETUP, ST_LAUNCH, ST_WALK,
        ST_DRAIN, ST_FIX, ST_SCAN, ST_FINISH, ST_RESP
    } state_t;

    state_t state_reg;

    logic [17:0]    kib_reg;
    logic [CW-1:0]  total_reg;
    logic [CW-1:0]  used_reg;
    logic           init_pend_reg;
    logic [AW-1:0]  clr_reg;

    logic [2:0]     op_reg;
    logic [31:0]    addr_reg;
    logic [31:0]    len_reg;
    logic           ok_reg;
    logic [31:0]    res_addr_reg;

    logic [31:0]    start_full_reg;
    logic [CW-1:0]  end_reg;
    logic [BW-1:0]  start_reg;
    logic [BW-1:0]  em1_reg;
    logic [CW-1:0]  cnt_reg;
    logic [AW-1:0]  walk_reg;
    logic [AW-1:0]  walk_last_reg;
    logic           set_reg;
    logic           fix_done_reg;

    // read-modify-write stage: the word read last cycle is written back now
    logic                          pv_reg;
    logic [AW-1:0]                 pa_reg;
    logic [bfa_pkg::WORD_BITS-1:0] pm_reg;
    logic                          ps_reg;

    // allocation scan
    logic [AW:0]    scan_rd_reg;
    logic [AW:0]    limit_reg;
    logic           sv_reg;
    logic [AW-1:0]  sidx_reg;
    logic [RW-1:0]  run_reg;

    logic           m_valid_reg;
    logic [31:0]    m_addr_reg;
    logic           m_ok_reg;
    logic [15:0]    m_used_reg;
    logic [15:0]    m_free_reg;

    // ------------------------------------------------------------------
    // Bitmap memory ports
    // ------------------------------------------------------------------
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [bfa_pkg::WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [bfa_pkg::WORD_BITS-1:0] ram_rdata;
    logic                          rd_en;
    logic                          walk_issue;
    logic [bfa_pkg::WORD_BITS-1:0] walk_mask;

    bfa_bitmap_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Mask of the blocks of the current word that lie in [start, end).
    always_comb begin
        logic [bfa_pkg::WORD_LOG2-1:0] lo;
        logic [bfa_pkg::WORD_LOG2-1:0] hi;
        lo = (walk_reg == start_reg[BW-1:bfa_pkg::WORD_LOG2])
           ? start_reg[bfa_pkg::WORD_LOG2-1:0] : '0;
        hi = (walk_reg == walk_last_reg)
           ? em1_reg[bfa_pkg::WORD_LOG2-1:0] : '1;
        walk_mask = ({bfa_pkg::WORD_BITS{1'b1}} << lo)
                  & ({bfa_pkg::WORD_BITS{1'b1}} >> (5'd31 - hi));
    end

    assign walk_issue = (state_reg == ST_WALK) || (state_reg == ST_FIX);

    always_comb begin
        ram_raddr = walk_reg;
        rd_en     = 1'b0;
        case (state_reg)
            ST_WALK: begin
                rd_en = 1'b1;
            end
            ST_FIX: begin
                ram_raddr = '0;
                rd_en     = 1'b1;
            end
            ST_SCAN: begin
                ram_raddr = scan_rd_reg[AW-1:0];
                rd_en     = (scan_rd_reg < limit_reg);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Fill sweep owns the write port; otherwise write back the modified word.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '1;
        end else begin
            ram_we    = pv_reg;
            ram_waddr = pa_reg;
            ram_wdata = ps_reg ? (ram_rdata | pm_reg) : (ram_rdata & ~pm_reg);
        end
    end

    // ------------------------------------------------------------------
    // Allocation word scanner
    // ------------------------------------------------------------------
    bfa_pkg::scan_hit_t hit;
    logic [RW-1:0]      run_out;

    bfa_word_scan #(
        .RW (RW)
    ) u_scan (
        .word    (ram_rdata),
        .run_in  (run_reg),
        .len     (RW'(len_reg[CW-1:0])),
        .hit     (hit),
        .run_out (run_out)
    );

    // ------------------------------------------------------------------
    // Arithmetic for setup and completion
    // ------------------------------------------------------------------
    logic [TW-1:0] tot_raw;
    logic [CW-1:0] tot_cap;
    logic [31:0]   frame;
    logic [31:0]   nblk;
    logic [33:0]   end_sum;
    logic [CW-1:0] free_c;
    logic [CW:0]   add_sum;
    logic [CW-1:0] add_sat;
    logic [CW-1:0] sub_sat;
    logic [BW-1:0] hit_last;
    logic [BW-1:0] hit_start;
    logic [63:0]   hit_bytes;
    logic [31:0]   used_ext;
    logic [31:0]   free_ext;

    assign tot_raw   = TW'({kib_reg, 10'd0}) >> BS_LOG2;
    assign tot_cap   = (tot_raw > TW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(tot_raw);
    assign frame     = addr_reg >> BS_LOG2;
    assign nblk      = (op_reg == bfa_pkg::OP_FREE_RUN) ? len_reg : (len_reg >> BS_LOG2);
    assign end_sum   = 34'(frame) + 34'(nblk);
    assign free_c    = total_reg - used_reg;
    assign add_sum   = (CW+1)'(used_reg) + (CW+1)'(cnt_reg);
    assign add_sat   = (add_sum > (CW+1)'(total_reg)) ? total_reg : add_sum[CW-1:0];
    assign sub_sat   = (cnt_reg >= used_reg) ? '0 : (used_reg - cnt_reg);
    assign hit_last  = {sidx_reg, hit.pos};
    assign hit_start = hit_last + BW'(1) - BW'(len_reg[CW-1:0]);
    assign hit_bytes = 64'(hit_start) << BS_LOG2;
    assign used_ext  = 32'(used_reg);
    assign free_ext  = 32'(free_c);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            kib_reg       <= '0;
            total_reg     <= '0;
            used_reg      <= '0;
            init_pend_reg <= 1'b0;
            clr_reg       <= '0;
            pv_reg        <= 1'b0;
            sv_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                kib_reg <= cfg_memory_size_kib;
            end
            // the response state loads the output register itself
            if (m_ready && state_reg != ST_RESP) begin
                m_valid_reg <= 1'b0;
            end

            // every word read for a walk comes back and is written next cycle
            pv_reg <= walk_issue;
            pa_reg <= ram_raddr;
            pm_reg <= (state_reg == ST_FIX) ? bfa_pkg::WORD_BITS'(1) : walk_mask;
            ps_reg <= (state_reg == ST_FIX) ? 1'b1 : set_reg;

            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MAP_WORDS - 1)) begin
                        init_pend_reg <= 1'b0;
                        state_reg     <= init_pend_reg ? ST_FINISH : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= s_opcode;
                        addr_reg     <= s_request_address;
                        len_reg      <= s_run_length;
                        ok_reg       <= 1'b1;
                        res_addr_reg <= '0;
                        state_reg    <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    case (op_reg)
                        bfa_pkg::OP_INIT: begin
                            total_reg     <= tot_cap;
                            used_reg      <= tot_cap;
                            clr_reg       <= '0;
                            init_pend_reg <= 1'b1;
                            state_reg     <= ST_CLEAR;
                        end
                        bfa_pkg::OP_REGION_FREE, bfa_pkg::OP_REGION_USED,
                        bfa_pkg::OP_FREE_RUN: begin
                            // clip the range to the installed blocks
                            end_reg        <= (end_sum > 34'(total_reg))
                                            ? total_reg : end_sum[CW-1:0];
                            start_full_reg <= frame;
                            set_reg        <= (op_reg == bfa_pkg::OP_REGION_USED);
                            fix_done_reg   <= 1'b0;
                            state_reg      <= ST_LAUNCH;
                        end
                        bfa_pkg::OP_ALLOC: begin
                            scan_rd_reg <= '0;
                            sv_reg      <= 1'b0;
                            run_reg     <= '0;
                            limit_reg   <= (AW+1)'(total_reg >> bfa_pkg::WORD_LOG2);
                            if (len_reg == '0 || len_reg > 32'(free_c)
                                || total_reg < CW'(bfa_pkg::WORD_BITS)) begin
                                ok_reg    <= 1'b0;
                                state_reg <= ST_FINISH;
                            end else begin
                                state_reg <= ST_SCAN;
                            end
                        end
                        default: begin
                            state_reg <= ST_FINISH;
                        end
                    endcase
                end
                ST_LAUNCH: begin
                    if (start_full_reg < 32'(end_reg)) begin
                        start_reg     <= start_full_reg[BW-1:0];
                        em1_reg       <= BW'(end_reg - CW'(1));
                        cnt_reg       <= end_reg - CW'(start_full_reg[BW-1:0]);
                        walk_reg      <= start_full_reg[BW-1:bfa_pkg::WORD_LOG2];
                        walk_last_reg <= AW'(BW'(end_reg - CW'(1)) >> bfa_pkg::WORD_LOG2);
                        state_reg     <= ST_WALK;
                    end else begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_WALK: begin
                    walk_reg <= walk_reg + AW'(1);
                    if (walk_reg == walk_last_reg) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // hold until the last write-back has landed
                    if (!pv_reg) begin
                        if (op_reg == bfa_pkg::OP_REGION_FREE && !fix_done_reg) begin
                            state_reg <= ST_FIX;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FIX: begin
                    fix_done_reg <= 1'b1;
                    state_reg    <= ST_DRAIN;
                end
                ST_SCAN: begin
                    if (scan_rd_reg < limit_reg) begin
                        scan_rd_reg <= scan_rd_reg + (AW+1)'(1);
                        sidx_reg    <= scan_rd_reg[AW-1:0];
                        sv_reg      <= 1'b1;
                    end else begin
                        sv_reg <= 1'b0;
                    end
                    if (sv_reg) begin
                        if (hit.found) begin
                            // ignore the read still in flight and mark the run
                            start_reg     <= hit_start;
                            em1_reg       <= hit_last;
                            cnt_reg       <= len_reg[CW-1:0];
                            walk_reg      <= hit_start[BW-1:bfa_pkg::WORD_LOG2];
                            walk_last_reg <= sidx_reg;
                            set_reg       <= 1'b1;
                            fix_done_reg  <= 1'b1;
                            res_addr_reg  <= hit_bytes[31:0];
                            state_reg     <= ST_WALK;
                        end else begin
                            run_reg <= run_out;
                            if ((AW+1)'(sidx_reg) == limit_reg - (AW+1)'(1)) begin
                                ok_reg    <= 1'b0;
                                state_reg <= ST_FINISH;
                            end
                        end
                    end
                end
                ST_FINISH: begin
                    case (op_reg)
                        bfa_pkg::OP_REGION_FREE, bfa_pkg::OP_FREE_RUN: begin
                            used_reg <= sub_sat;
                        end
                        bfa_pkg::OP_REGION_USED: begin
                            used_reg <= add_sat;
                        end
                        bfa_pkg::OP_ALLOC: begin
                            if (ok_reg) begin
                                used_reg <= add_sat;
                            end
                        end
                        default: begin
                            used_reg <= used_reg;
                        end
                    endcase
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    // advance once the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_addr_reg  <= res_addr_reg;
                        m_ok_reg    <= ok_reg;
                        m_used_reg  <= used_ext[15:0];
                        m_free_reg  <= free_ext[15:0];
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_address = m_addr_reg;
    assign m_success        = m_ok_reg;
    assign m_used_count     = m_used_reg;
    assign m_free_count     = m_free_reg;

`ifndef SYNTHESIS
    a_used_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= total_reg)
        else $error("used count above total");

    a_no_rmw_hazard: assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg && rd_en |-> ram_raddr != pa_reg)
        else $error("read of a word with a write-back in flight");

    a_fail_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_success |-> m_result_address == 32'd0)
        else $error("failed allocation with nonzero address");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("request taken during bitmap fill");
`endif

endmodule

`default_nettype wire
